[rtl/rms_pkg.sv]
// ----------------------------------------------------------------------------
// rms_pkg
// Shared constants and types of the block rms meter.
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int MAX_SAMPLES = 1024;

  localparam int SAMPLE_W  = 16;
  localparam int RMS_W     = 16;
  localparam int OUT_CNT_W = 11;
  localparam int SQ_W      = 2 * SAMPLE_W;

  // count holds 0..MAX_SAMPLES
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  // sum of squares is at most MAX_SAMPLES * 2^30
  localparam int SUM_W = CNT_W + 30;
  // mean is at most 2^30; kept even for the root
  localparam int MEAN_W = 2 * RMS_W;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             overflow;
  } job_t;

endpackage

[rtl/rms_in_if.sv]
// ----------------------------------------------------------------------------
// rms_in_if
// Sample channel: valid/ready handshake with one signed sample per item.
// ----------------------------------------------------------------------------
interface rms_in_if;
  logic                         valid;
  logic                         ready;
  logic [rms_pkg::SAMPLE_W-1:0] sample;
  logic                         last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

[rtl/rms_out_if.sv]
// ----------------------------------------------------------------------------
// rms_out_if
// Result channel: valid/ready handshake with one block result per item.
// ----------------------------------------------------------------------------
interface rms_out_if;
  logic                          valid;
  logic                          ready;
  logic [rms_pkg::RMS_W-1:0]     rms_value;
  logic [rms_pkg::OUT_CNT_W-1:0] sample_count;
  logic                          overflow;

  modport source (output valid, output rms_value, output sample_count,
                  output overflow, input ready);
  modport sink   (input valid, input rms_value, input sample_count,
                  input overflow, output ready);
endinterface

[rtl/rms_front.sv]
// ----------------------------------------------------------------------------
// rms_front
// Squares each sample and accumulates it; on the last sample of a block
// hands sum, count and overflow flag to the job queue.
// ----------------------------------------------------------------------------
module rms_front (
  input  logic            clk,
  input  logic            rst,
  rms_in_if.sink          samples,
  output logic            push,
  output rms_pkg::job_t   job,
  input  logic            q_ready
);

  logic [rms_pkg::SUM_W-1:0]    sum;
  logic [rms_pkg::CNT_W-1:0]    count;
  logic                         overflowed;

  logic                         fire;
  logic                         room;
  logic [rms_pkg::SAMPLE_W-1:0] mag;
  logic [rms_pkg::SQ_W-1:0]     square;
  logic [rms_pkg::SUM_W-1:0]    sum_next;
  logic [rms_pkg::CNT_W-1:0]    count_next;
  logic                         overflowed_next;

  // only a last item needs a free queue slot
  assign samples.ready = q_ready || !samples.last;
  assign fire          = samples.valid && samples.ready;

  assign room   = count < rms_pkg::CNT_W'(rms_pkg::MAX_SAMPLES);
  assign mag    = samples.sample[rms_pkg::SAMPLE_W-1] ? (~samples.sample + 1'b1)
                                                      : samples.sample;
  assign square = rms_pkg::SQ_W'(mag) * rms_pkg::SQ_W'(mag);

  always_comb begin
    if (room) begin
      sum_next        = sum + rms_pkg::SUM_W'(square);
      count_next      = count + 1'b1;
      overflowed_next = overflowed;
    end else begin
      sum_next        = sum;
      count_next      = count;
      overflowed_next = 1'b1;
    end
  end

  assign push         = fire && samples.last;
  assign job.sum      = sum_next;
  assign job.count    = count_next;
  assign job.overflow = overflowed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum        <= '0;
      count      <= '0;
      overflowed <= 1'b0;
    end else if (fire) begin
      if (samples.last) begin
        sum        <= '0;
        count      <= '0;
        overflowed <= 1'b0;
      end else begin
        sum        <= sum_next;
        count      <= count_next;
        overflowed <= overflowed_next;
      end
    end
  end

endmodule

[rtl/rms_queue.sv]
// ----------------------------------------------------------------------------
// rms_queue
// Short register queue of finished block totals between front and back.
// ----------------------------------------------------------------------------
module rms_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rms_pkg::job_t wr_job,
  output logic          wr_ready,
  input  logic          pop,
  output logic          rd_valid,
  output rms_pkg::job_t rd_job
);

  rms_pkg::job_t                entries [rms_pkg::Q_DEPTH];
  logic [rms_pkg::Q_PTR_W-1:0]  wr_ptr;
  logic [rms_pkg::Q_PTR_W-1:0]  rd_ptr;
  logic [rms_pkg::Q_CNT_W-1:0]  fill;
  logic                         do_push;
  logic                         do_pop;

  assign wr_ready = fill != rms_pkg::Q_CNT_W'(rms_pkg::Q_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_job   = entries[rd_ptr];
  assign do_push  = push && wr_ready;
  assign do_pop   = pop && rd_valid;

  function automatic logic [rms_pkg::Q_PTR_W-1:0] bump(
    input logic [rms_pkg::Q_PTR_W-1:0] p
  );
    if (p == rms_pkg::Q_PTR_W'(rms_pkg::Q_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[rtl/rms_back.sv]
// ----------------------------------------------------------------------------
// rms_back
// Divides a block's sum of squares by its count one quotient bit a cycle,
// then takes the integer square root one digit a cycle, and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module rms_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  rms_pkg::job_t q_job,
  output logic          pop,
  rms_out_if.source     results
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SQRT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam int STEP_W = $clog2(rms_pkg::SUM_W);
  localparam int REM_W  = rms_pkg::RMS_W + 1;

  logic [1:0]                  state;
  logic [STEP_W-1:0]           step;

  logic [rms_pkg::SUM_W-1:0]   quot;
  logic [rms_pkg::CNT_W-1:0]   div_rem;
  logic [rms_pkg::CNT_W-1:0]   divisor;
  logic                        ovf;

  logic [rms_pkg::MEAN_W-1:0]  rad;
  logic [REM_W-1:0]            sq_rem;
  logic [rms_pkg::RMS_W-1:0]   root;

  logic [rms_pkg::CNT_W:0]     div_sh;
  logic                        div_ge;
  logic [REM_W+1:0]            sq_sh;
  logic [REM_W+1:0]            trial;
  logic                        sq_ge;

  logic                        out_valid;
  logic [rms_pkg::RMS_W-1:0]   out_rms;
  logic [rms_pkg::OUT_CNT_W-1:0] out_cnt;
  logic                        out_ovf;

  assign div_sh = {div_rem, quot[rms_pkg::SUM_W-1]};
  assign div_ge = div_sh >= {1'b0, divisor};

  assign sq_sh  = {sq_rem, rad[rms_pkg::MEAN_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign sq_ge  = sq_sh >= trial;

  assign pop = (state == ST_IDLE) && q_valid;

  assign results.valid        = out_valid;
  assign results.rms_value    = out_rms;
  assign results.sample_count = out_cnt;
  assign results.overflow     = out_ovf;

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        quot    <= q_job.sum;
        divisor <= q_job.count;
        ovf     <= q_job.overflow;
        div_rem <= '0;
      end
      ST_DIV: begin
        div_rem <= div_ge ? rms_pkg::CNT_W'(div_sh - {1'b0, divisor})
                          : rms_pkg::CNT_W'(div_sh);
        quot    <= {quot[rms_pkg::SUM_W-2:0], div_ge};
        // quotient complete: load the radicand
        if (step == '0) begin
          rad    <= rms_pkg::MEAN_W'({quot[rms_pkg::SUM_W-2:0], div_ge});
          sq_rem <= '0;
          root   <= '0;
        end
      end
      ST_SQRT: begin
        sq_rem <= sq_ge ? REM_W'(sq_sh - trial) : REM_W'(sq_sh);
        root   <= {root[rms_pkg::RMS_W-2:0], sq_ge};
        rad    <= {rad[rms_pkg::MEAN_W-3:0], 2'b00};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result may replace the one taken in the same cycle
      if ((state == ST_DONE) && (!out_valid || results.ready)) begin
        out_valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_DIV;
            step  <= STEP_W'(rms_pkg::SUM_W - 1);
          end
        end
        ST_DIV: begin
          if (step == '0) begin
            state <= ST_SQRT;
            step  <= STEP_W'(rms_pkg::RMS_W - 1);
          end else begin
            step <= step - 1'b1;
          end
        end
        ST_SQRT: begin
          if (step == '0) begin
            state <= ST_DONE;
          end else begin
            step <= step - 1'b1;
          end
        end
        ST_DONE: begin
          if (!out_valid || results.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!out_valid || results.ready)) begin
      out_rms <= root;
      out_cnt <= rms_pkg::OUT_CNT_W'(divisor);
      out_ovf <= ovf;
    end
  end

endmodule

[rtl/block_rms_meter_top.sv]
// ----------------------------------------------------------------------------
// block_rms_meter_top
// RMS of blocks of signed Q1.15 samples, one result per block.
//
//   channel   dir  item fields                        handshake
//   samples   in   sample[15:0] signed, last          valid / ready
//   results   out  rms_value[15:0], sample_count[10:0],
//                  overflow                           valid / ready
//
// samples are taken one per cycle unless a last sample stalls; squaring and accumulation are combinational
// each finished block waits in a 2-entry queue for the back end, which works
// on one block at a time until its result is out: serial divide, serial root
// a last sample stalls only while the queue is full; others never stall
// reset clears sums, counts, queue fill and output valid flag at once
// ----------------------------------------------------------------------------
module block_rms_meter_top (
  input  logic     clk,
  input  logic     rst,
  rms_in_if.sink   samples,
  rms_out_if.source results
);

  logic          push;
  rms_pkg::job_t wr_job;
  logic          q_ready;
  logic          pop;
  logic          q_valid;
  rms_pkg::job_t rd_job;

  rms_front u_front (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .push    (push),
    .job     (wr_job),
    .q_ready (q_ready)
  );

  rms_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_job   (wr_job),
    .wr_ready (q_ready),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_job   (rd_job)
  );

  rms_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (rd_job),
    .pop     (pop),
    .results (results)
  );

endmodule
